// ----- rtl/intermod_frequency_checker_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef INTERMOD_FREQUENCY_CHECKER_MACROS_SVH
`define INTERMOD_FREQUENCY_CHECKER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define IFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication with the consequent checked in the next cycle.
`define IFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/ifc_pkg.sv -----
// Package with the shared types and codes of the intermod frequency checker.
`timescale 1ns / 1ps
`default_nettype none
package ifc_pkg;
	localparam logic [1:0] OP_CHECK  = 2'd0;
	localparam logic [1:0] OP_ASSIGN = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_TWO  = 2'd1;
	localparam logic [1:0] MODE_THREE = 2'd2;
	localparam logic [1:0] MODE_FIFTH = 2'd3;

	localparam logic [1:0] REG_GUARD   = 2'd0;
	localparam logic [1:0] REG_SPACING = 2'd1;
	localparam logic [1:0] REG_MODE    = 2'd2;

	// Test kinds the datapath evaluates for one (i, j, k) step.
	typedef enum logic [3:0] {
		T_SPACING,   // |f - a| < spacing, a = table[i]
		T_P21,       // f near 2a - b
		T_P32,       // f near 3a - 2b
		T_P3X,       // f near a + b - c
		T_N21F,      // 2f - a near table[k] or f
		T_N21A,      // 2a - f
		T_N32F,      // 3f - 2a
		T_N32A,      // 3a - 2f
		T_N3AB,      // f + a - b
		T_N3BA,      // f + b - a
		T_N3F        // a + b - f
	} test_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_RUN,
		S_WAIT,
		S_DONE,
		S_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic   start;     // latch candidate and clear fail flag
		logic   rd;        // issue a table read for the current step
		logic   eval;      // evaluate the step read last cycle
		logic   self_cmp;  // compare against f instead of table[k]
		test_t  test;
		logic   store;     // write candidate at the count
		logic   clear;     // empty the table
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic   fail;
	} dp_stat_t;
endpackage
`default_nettype wire

// ----- rtl/intermod_frequency_checker.sv -----
// Top level of the intermod frequency checker.
//
// Usage: write guard_khz (0x0), min_spacing_khz (0x4) and imd_mode (0x8) over
// the APB port while the block is idle. Items arrive on s_axis: tdata carries
// opcode in bits 1:0 and candidate_khz in bits 23:2. Opcode zero checks the
// candidate, opcode one checks and stores it when it passes and the table has
// room, opcode two empties the table; opcode three acts as a check.
// One result item leaves on m_axis per input item.
// A clear, or an item that meets an empty table, runs no table walk. Otherwise
// the controller runs the table walks step by step through one shared compare
// unit. Skipped index combinations are still stepped through, so the walks
// run about 4*n*n*n steps with every product enabled over n stored carriers
// (about 140k for a full table of 32). A walk ends once a failing step has set
// the fail flag. One item is in flight at a time.
// Reset empties the table and clears the registers to zero. A stalled
// receiver holds the result in the output register; no new item is taken
// until the result has been delivered.
`timescale 1ns / 1ps
`default_nettype none
module intermod_frequency_checker #(
	parameter int MAX_CARRIERS = 32,
	parameter int FREQ_BITS = 22
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [3:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	// opcode [1:0], candidate_khz [FREQ_BITS+1:2], zero fill
	input  wire [((FREQ_BITS + 2 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	// compatible [0], stored [1], table_full [2], carrier_total [8:3], zero fill
	output logic [15:0] m_axis_tdata
);
	localparam int IW = $clog2(MAX_CARRIERS);
	localparam int CW = $clog2(MAX_CARRIERS + 1);

	logic [15:0] guard_q, spacing_q;
	logic [1:0]  mode_q;
	logic        in_fire;
	logic        idle;
	ifc_pkg::dp_cmd_t  cmd;
	ifc_pkg::dp_stat_t stat;
	logic [IW-1:0] idx_i, idx_j, idx_k;
	logic [CW-1:0] count;
	logic res_valid, res_c, res_s, res_f;

	assign pready = 1'b1;

	// Register file: written on the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q <= '0;
			spacing_q <= '0;
			mode_q <= ifc_pkg::MODE_OFF;
		end else if (psel && penable && pwrite) begin
			priority case (paddr[3:2])
				ifc_pkg::REG_GUARD:   guard_q <= pwdata[15:0];
				ifc_pkg::REG_SPACING: spacing_q <= pwdata[15:0];
				ifc_pkg::REG_MODE:    mode_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			ifc_pkg::REG_GUARD:   prdata = {16'd0, guard_q};
			ifc_pkg::REG_SPACING: prdata = {16'd0, spacing_q};
			ifc_pkg::REG_MODE:    prdata = {30'd0, mode_q};
			default:              prdata = '0;
		endcase
	end

	assign s_axis_tready = idle;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	ifc_controller #(.MAX_CARRIERS(MAX_CARRIERS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.opcode(s_axis_tdata[1:0]), .imd_mode(mode_q),
		.out_busy(m_axis_tvalid && !m_axis_tready), .stat(stat), .cmd(cmd),
		.idx_i(idx_i), .idx_j(idx_j), .idx_k(idx_k), .count(count), .idle(idle),
		.res_valid(res_valid), .res_compatible(res_c), .res_stored(res_s),
		.res_full(res_f)
	);

	ifc_datapath #(.MAX_CARRIERS(MAX_CARRIERS), .FREQ_BITS(FREQ_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .idx_i(idx_i), .idx_j(idx_j),
		.idx_k(idx_k), .count(count), .candidate(s_axis_tdata[FREQ_BITS+1:2]),
		.guard_khz(guard_q), .min_spacing_khz(spacing_q), .stat(stat)
	);

	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata = {7'd0, 6'(count), res_f, res_s, res_c};
endmodule
`default_nettype wire

// ----- rtl/ifc_datapath.sv -----
// Datapath: carrier memory, product forming and guard comparisons.
`timescale 1ns / 1ps
`default_nettype none
module ifc_datapath #(
	parameter int MAX_CARRIERS = 32,
	parameter int FREQ_BITS = 22,
	parameter int IW = $clog2(MAX_CARRIERS),
	parameter int CW = $clog2(MAX_CARRIERS + 1)
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire ifc_pkg::dp_cmd_t cmd,
	input  wire [IW-1:0]          idx_i,
	input  wire [IW-1:0]          idx_j,
	input  wire [IW-1:0]          idx_k,
	input  wire [CW-1:0]          count,
	input  wire [FREQ_BITS-1:0]   candidate,
	input  wire [15:0]            guard_khz,
	input  wire [15:0]            min_spacing_khz,
	output ifc_pkg::dp_stat_t     stat
);
	localparam int PW = FREQ_BITS + 4;

	logic [FREQ_BITS-1:0] mem [MAX_CARRIERS];
	logic [FREQ_BITS-1:0] f_q;
	logic [FREQ_BITS-1:0] a_q, b_q, c_q;
	logic                 fail_q;
	logic signed [PW-1:0] prod_s1, ref_s1;
	logic                 spc_s1, vld_s1;
	logic signed [PW-1:0] fs, as, bs, cs, p, r, d;

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[count[IW-1:0]] <= f_q;
		end
		if (cmd.rd) begin
			a_q <= mem[idx_i];
			b_q <= mem[idx_j];
			c_q <= mem[idx_k];
		end
		if (cmd.start) begin
			f_q <= candidate;
		end
	end

	always_comb begin
		fs = PW'($signed({1'b0, f_q}));
		as = PW'($signed({1'b0, a_q}));
		bs = PW'($signed({1'b0, b_q}));
		cs = PW'($signed({1'b0, c_q}));
		r = cmd.self_cmp ? fs : cs;
		p = '0;
		unique case (cmd.test)
			ifc_pkg::T_SPACING: begin p = as; r = fs; end
			ifc_pkg::T_P21:     begin p = PW'(2 * as - bs); r = fs; end
			ifc_pkg::T_P32:     begin p = PW'(3 * as - 2 * bs); r = fs; end
			ifc_pkg::T_P3X:     begin p = as + bs - cs; r = fs; end
			ifc_pkg::T_N21F:    p = PW'(2 * fs - as);
			ifc_pkg::T_N21A:    p = PW'(2 * as - fs);
			ifc_pkg::T_N32F:    p = PW'(3 * fs - 2 * as);
			ifc_pkg::T_N32A:    p = PW'(3 * as - 2 * fs);
			ifc_pkg::T_N3AB:    p = fs + as - bs;
			ifc_pkg::T_N3BA:    p = fs + bs - as;
			ifc_pkg::T_N3F:     p = as + bs - fs;
			default:            p = as;
		endcase
	end

	// Stage 1 registers the product; stage 2 compares it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.eval;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= p;
		ref_s1  <= r;
		spc_s1  <= (cmd.test == ifc_pkg::T_SPACING);
	end

	always_comb begin
		d = prod_s1 - ref_s1;
		if (d < 0) begin
			d = -d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q <= 1'b0;
		end else if (cmd.start) begin
			fail_q <= 1'b0;
		end else if (vld_s1) begin
			if (spc_s1) begin
				if (d < PW'(min_spacing_khz)) fail_q <= 1'b1;
			end else if (d <= PW'(guard_khz)) begin
				fail_q <= 1'b1;
			end
		end
	end

	assign stat.fail = fail_q;

endmodule
`default_nettype wire

// ----- rtl/ifc_controller.sv -----
// Controller: sequences the table walks for one item and builds the result.
`timescale 1ns / 1ps
`default_nettype none
module ifc_controller #(
	parameter int MAX_CARRIERS = 32,
	parameter int IW = $clog2(MAX_CARRIERS),
	parameter int CW = $clog2(MAX_CARRIERS + 1)
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_fire,
	input  wire [1:0]              opcode,
	input  wire [1:0]              imd_mode,
	input  wire                    out_busy,
	input  wire ifc_pkg::dp_stat_t stat,
	output ifc_pkg::dp_cmd_t       cmd,
	output logic [IW-1:0]          idx_i,
	output logic [IW-1:0]          idx_j,
	output logic [IW-1:0]          idx_k,
	output logic [CW-1:0]          count,
	output logic                   idle,
	output logic                   res_valid,
	output logic                   res_compatible,
	output logic                   res_stored,
	output logic                   res_full
);
	ifc_pkg::state_t state_q, state_d;
	ifc_pkg::test_t  test_q;
	logic [CW-1:0]   i_q, j_q, k_q;
	logic            self_q;
	logic [1:0]      op_q;
	logic [1:0]      mode_q;
	logic [1:0]      drain_q;
	logic            step;
	logic            last;
	logic            k_end;
	ifc_pkg::test_t  next_test;
	logic            next_valid;
	logic            skip;
	logic [CW-1:0]   n;
	logic            run_d1;
	ifc_pkg::test_t  test_d1;
	logic            self_d1, skip_d1;

	assign n = count;

	// Skip index combinations the model leaves out.
	always_comb begin
		skip = 1'b0;
		unique case (test_q)
			ifc_pkg::T_P21, ifc_pkg::T_P32: skip = (i_q == j_q);
			ifc_pkg::T_P3X: skip = (j_q <= i_q) || (k_q == i_q) || (k_q == j_q);
			ifc_pkg::T_N3AB, ifc_pkg::T_N3BA, ifc_pkg::T_N3F: skip = (j_q <= i_q);
			default: skip = 1'b0;
		endcase
	end

	// Walked loops: k for a + b - c and the set-hit tests (k == n is f itself).
	function automatic logic uses_k(ifc_pkg::test_t t);
		return t == ifc_pkg::T_P3X || t >= ifc_pkg::T_N21F;
	endfunction
	function automatic logic uses_j(ifc_pkg::test_t t);
		return t == ifc_pkg::T_P21 || t == ifc_pkg::T_P32 || t == ifc_pkg::T_P3X ||
			t >= ifc_pkg::T_N3AB;
	endfunction

	// The k walk ends on the last carrier for a + b - c, else on the candidate.
	always_comb begin
		k_end = (test_q == ifc_pkg::T_P3X) ? (k_q == n - 1'b1) : (k_q == n);
	end

	// Next enabled test after the current one.
	always_comb begin
		next_test = test_q;
		next_valid = 1'b0;
		priority case (test_q)
			ifc_pkg::T_SPACING: begin
				next_valid = (mode_q != ifc_pkg::MODE_OFF);
				next_test = ifc_pkg::T_P21;
			end
			ifc_pkg::T_P21: begin
				next_valid = 1'b1;
				next_test = (mode_q == ifc_pkg::MODE_FIFTH) ? ifc_pkg::T_P32 :
					(mode_q == ifc_pkg::MODE_THREE) ? ifc_pkg::T_P3X : ifc_pkg::T_N21F;
			end
			ifc_pkg::T_P32: begin
				next_valid = 1'b1; next_test = ifc_pkg::T_P3X;
			end
			ifc_pkg::T_P3X: begin
				next_valid = 1'b1; next_test = ifc_pkg::T_N21F;
			end
			ifc_pkg::T_N21F: begin
				next_valid = 1'b1; next_test = ifc_pkg::T_N21A;
			end
			ifc_pkg::T_N21A: begin
				next_valid = 1'b1;
				next_test = (mode_q == ifc_pkg::MODE_FIFTH) ? ifc_pkg::T_N32F :
					ifc_pkg::T_N3AB;
				if (mode_q == ifc_pkg::MODE_TWO) next_valid = 1'b0;
			end
			ifc_pkg::T_N32F: begin
				next_valid = 1'b1; next_test = ifc_pkg::T_N32A;
			end
			ifc_pkg::T_N32A: begin
				next_valid = 1'b1; next_test = ifc_pkg::T_N3AB;
			end
			ifc_pkg::T_N3AB: begin
				next_valid = 1'b1; next_test = ifc_pkg::T_N3BA;
			end
			ifc_pkg::T_N3BA: begin
				next_valid = 1'b1; next_test = ifc_pkg::T_N3F;
			end
			default: next_valid = 1'b0;
		endcase
	end

	// End of the walk of the current test.
	always_comb begin
		last = (i_q == n - 1'b1) &&
			(!uses_j(test_q) || j_q == n - 1'b1) &&
			(!uses_k(test_q) || k_end);
	end

	assign step = (state_q == ifc_pkg::S_RUN);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ifc_pkg::S_IDLE: if (in_fire) state_d = ifc_pkg::S_LOAD;
			ifc_pkg::S_LOAD: begin
				if (op_q == ifc_pkg::OP_CLEAR || n == '0) state_d = ifc_pkg::S_WAIT;
				else state_d = ifc_pkg::S_RUN;
			end
			ifc_pkg::S_RUN: if (stat.fail || (last && !next_valid)) state_d = ifc_pkg::S_WAIT;
			ifc_pkg::S_WAIT: if (drain_q == 2'd0) state_d = ifc_pkg::S_DONE;
			ifc_pkg::S_DONE: state_d = ifc_pkg::S_OUT;
			ifc_pkg::S_OUT: if (!out_busy) state_d = ifc_pkg::S_IDLE;
			default: state_d = ifc_pkg::S_IDLE;
		endcase
	end

	// The eval strobe and its test/self are delayed to line up with read data;
	// skipped combinations are dropped there.
	always_comb begin
		cmd = '0;
		cmd.start = in_fire;
		cmd.rd = step;
		cmd.test = test_d1;
		cmd.self_cmp = self_d1;
		cmd.eval = run_d1 && !skip_d1;
		cmd.clear = 1'b0;
		cmd.store = 1'b0;
		if (state_q == ifc_pkg::S_DONE) begin
			cmd.store = (op_q == ifc_pkg::OP_ASSIGN) && !stat.fail &&
				(n < CW'(MAX_CARRIERS));
			cmd.clear = (op_q == ifc_pkg::OP_CLEAR);
		end
		idle = (state_q == ifc_pkg::S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifc_pkg::S_IDLE;
			count <= '0;
			res_valid <= 1'b0;
			run_d1 <= 1'b0;
			drain_q <= '0;
			op_q <= ifc_pkg::OP_CHECK;
			mode_q <= ifc_pkg::MODE_OFF;
			test_q <= ifc_pkg::T_SPACING;
			i_q <= '0; j_q <= '0; k_q <= '0; self_q <= 1'b0;
			res_compatible <= 1'b0; res_stored <= 1'b0; res_full <= 1'b0;
			test_d1 <= ifc_pkg::T_SPACING; self_d1 <= 1'b0; skip_d1 <= 1'b0;
		end else begin
			state_q <= state_d;
			run_d1 <= step;
			test_d1 <= test_q; self_d1 <= self_q; skip_d1 <= skip;
			if (in_fire) begin
				op_q <= opcode;
				mode_q <= imd_mode;
				test_q <= ifc_pkg::T_SPACING;
				i_q <= '0; j_q <= '0; k_q <= '0; self_q <= 1'b0;
			end
			if (state_q == ifc_pkg::S_RUN) begin
				drain_q <= 2'd3;
				if (last) begin
					test_q <= next_test;
					i_q <= '0; j_q <= '0; k_q <= '0; self_q <= 1'b0;
				end else if (uses_k(test_q) && !k_end) begin
					k_q <= k_q + 1'b1;
					self_q <= (test_q != ifc_pkg::T_P3X) && (k_q + 1'b1 == n);
				end else begin
					k_q <= '0; self_q <= 1'b0;
					if (uses_j(test_q) && j_q != n - 1'b1) begin
						j_q <= j_q + 1'b1;
					end else begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end
				end
			end else if (drain_q != 2'd0) begin
				drain_q <= drain_q - 1'b1;
			end
			if (state_q == ifc_pkg::S_DONE) begin
				res_valid <= 1'b1;
				res_compatible <= (op_q != ifc_pkg::OP_CLEAR) && !stat.fail;
				res_stored <= cmd.store;
				res_full <= (op_q == ifc_pkg::OP_ASSIGN) && !stat.fail &&
					(n >= CW'(MAX_CARRIERS));
				if (cmd.store) count <= count + 1'b1;
				if (cmd.clear) count <= '0;
			end else if (state_q == ifc_pkg::S_OUT && !out_busy) begin
				res_valid <= 1'b0;
			end
		end
	end

	// Table addresses of the current step; k == n stands for the candidate.
	always_comb begin
		idx_i = i_q[IW-1:0];
		idx_j = j_q[IW-1:0];
		idx_k = (k_q >= n) ? '0 : k_q[IW-1:0];
	end
endmodule
`default_nettype wire

// ----- rtl/ifc_checker.sv -----
// Port-level checker for the intermod frequency checker.
`timescale 1ns / 1ps
`default_nettype none
`include "intermod_frequency_checker_macros.svh"
module ifc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [15:0] m_axis_tdata
);
	`IFC_ASSERT_IMP(a_no_in_while_out, clk, arst_n, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
	`IFC_ASSERT_IMP(a_store_ok, clk, arst_n, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0], "stored without compatible")
	`IFC_ASSERT_IMP(a_full_excl, clk, arst_n, m_axis_tvalid, !(m_axis_tdata[1] && m_axis_tdata[2]), "stored and full together")
	`IFC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule
bind intermod_frequency_checker ifc_checker u_ifc_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
